@@ rtl/core/block_cache_directory_round_robin_macros.svh @@
// Assertion helpers for the block cache directory.
`ifndef BLOCK_CACHE_DIRECTORY_ROUND_ROBIN_MACROS_SVH
`define BLOCK_CACHE_DIRECTORY_ROUND_ROBIN_MACROS_SVH

`define BCD_ASSERT_IMPL(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("bcd check failed");

`define BCD_ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("bcd check failed");

`endif

@@ rtl/core/bcd_pkg.sv @@
package bcd_pkg;

	typedef enum logic [1:0] {
		ACT_LOOKUP   = 2'd0,
		ACT_ALLOCATE = 2'd1,
		ACT_MARK     = 2'd2,
		ACT_FLUSH    = 2'd3
	} action_t;

	localparam logic [0:0] REG_NUM_PROCESSES = 1'b0;
	localparam logic [0:0] REG_NUM_BLOCKS    = 1'b1;

	// owner remainder runs four bits of the block per cycle
	localparam logic [2:0] OWN_STEPS = 3'd4;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture request
		logic exec;      // do lookup/allocate/mark, form result
		logic scan;      // flush: emit write-back for current scan slot
		logic scan_next; // advance scan index
		logic clear;     // invalidate all slots
		logic none;      // flush with nothing dirty
		logic last;      // result is final
	} bcd_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic flush;     // captured action is a flush
		logic wb;        // current result carries an in-range write-back
		logic own_busy;  // owner remainder needs more than one step
		logic more;      // another dirty slot above the found one
		logic any;       // any dirty valid slot at all
	} bcd_sts_t;

endpackage

@@ rtl/core/bcd_ctrl.sv @@
module bcd_ctrl import bcd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  bcd_sts_t sts,
	output bcd_cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_EXEC  = 6'b000010,
		ST_SCAN  = 6'b000100,
		ST_OUT   = 6'b001000,
		ST_FOUT  = 6'b010000,
		ST_OWN   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   last_q, last_d;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT) || (state_q == ST_FOUT);

	always_comb begin
		state_d = state_q;
		last_d  = last_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.flush) begin
					if (sts.any) begin
						state_d = ST_SCAN;
					end else begin
						cmd.none  = 1'b1;
						cmd.last  = 1'b1;
						cmd.clear = 1'b1;
						last_d    = 1'b1;
						state_d   = ST_FOUT;
					end
				end else begin
					cmd.exec = 1'b1;
					cmd.last = 1'b1;
					state_d  = sts.wb ? ST_OWN : ST_OUT;
				end
			end
			ST_SCAN: begin
				cmd.scan      = 1'b1;
				cmd.scan_next = 1'b1;
				cmd.last      = !sts.more;
				last_d        = !sts.more;
				if (!sts.more) cmd.clear = 1'b1;
				state_d = sts.wb ? ST_OWN : ST_FOUT;
			end
			ST_OWN: begin
				// hold until the owner remainder lands in the result
				if (!sts.own_busy) state_d = sts.flush ? ST_FOUT : ST_OUT;
			end
			ST_OUT: begin
				if (!out_stall) state_d = ST_IDLE;
			end
			ST_FOUT: begin
				if (!out_stall) state_d = last_q ? ST_IDLE : ST_SCAN;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			last_q  <= last_d;
		end
	end

endmodule

@@ rtl/core/bcd_datapath.sv @@
module bcd_datapath import bcd_pkg::*; #(
	parameter int ENTRIES    = 32,
	parameter int BLOCK_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [1:0]  action,
	input  logic [15:0] block_num,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [16:0] cfg_data,
	input  bcd_cmd_t    cmd,
	output bcd_sts_t    sts,
	output logic        hit,
	output logic [4:0]  slot,
	output logic        wb_valid,
	output logic [15:0] wb_block,
	output logic [7:0]  wb_owner,
	output logic        status,
	output logic        last
);

	localparam int IW = $clog2(ENTRIES);

	logic [BLOCK_BITS-1:0] tag_q [ENTRIES];
	logic [ENTRIES-1:0]    valid_q, dirty_q;
	logic [IW-1:0]         vptr_q;
	logic [8:0]            nproc_q;
	logic [16:0]           nblk_q;
	logic [1:0]            act_q;
	logic [BLOCK_BITS-1:0] blk_q;
	logic [IW-1:0]         scan_q;

	// one restoring step of block mod n; the partial remainder stays below n
	function automatic logic [8:0] rem_step(input logic [8:0] r, input logic b,
			input logic [8:0] n);
		logic [9:0] t;
		t = {r, b};
		if (t >= {1'b0, n}) t = t - {1'b0, n};
		return t[8:0];
	endfunction

	logic [8:0] nproc_eff;
	assign nproc_eff = (nproc_q == 9'd0) ? 9'd1 : ((nproc_q > 9'd256) ? 9'd256 : nproc_q);

	// lowest matching valid slot, lowest free slot, lowest dirty from scan_q
	logic [ENTRIES-1:0] match_v;
	logic [IW-1:0]      match_i, free_i, dirty_i;
	logic               match_f, free_f, dirty_f, more_f;
	logic [ENTRIES-1:0] dv;

	always_comb begin
		match_i = '0; match_f = 1'b0;
		free_i  = '0; free_f  = 1'b0;
		dirty_i = '0; dirty_f = 1'b0; more_f = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			match_v[i] = valid_q[i] && (tag_q[i] == blk_q);
			dv[i]      = valid_q[i] && dirty_q[i];
		end
		for (int i = ENTRIES-1; i >= 0; i--) begin
			if (match_v[i]) begin match_i = IW'(i); match_f = 1'b1; end
			if (!valid_q[i]) begin free_i = IW'(i); free_f = 1'b1; end
		end
		for (int i = ENTRIES-1; i >= 0; i--) begin
			if (dv[i] && IW'(i) >= scan_q) begin
				if (dirty_f) more_f = 1'b1;
				dirty_i = IW'(i); dirty_f = 1'b1;
			end
		end
	end

	logic [BLOCK_BITS-1:0] old_b, scan_b;
	logic                  old_rng, scan_rng;
	assign old_b    = tag_q[vptr_q];
	assign scan_b   = tag_q[dirty_i];
	assign old_rng  = ({1'b0, 16'(old_b)} < nblk_q);
	assign scan_rng = ({1'b0, 16'(scan_b)} < nblk_q);

	// owner remainder unit
	logic        own_need, own_start;
	logic [15:0] own_src, own_blk_q;
	logic [8:0]  own_rem_q, own_rem_d;
	logic [2:0]  own_cnt_q;

	assign own_need  = (act_q == ACT_FLUSH) ? scan_rng :
		((act_q == ACT_ALLOCATE) && !free_f && dirty_q[vptr_q] && old_rng);
	assign own_start = (cmd.exec || cmd.scan) && own_need;
	assign own_src   = (act_q == ACT_FLUSH) ? 16'(scan_b) : 16'(old_b);

	always_comb begin
		own_rem_d = own_rem_q;
		for (int k = 0; k < 4; k++)
			own_rem_d = rem_step(own_rem_d, own_blk_q[15-k], nproc_eff);
	end

	assign sts.flush    = (act_q == ACT_FLUSH);
	assign sts.wb       = own_need;
	assign sts.own_busy = (own_cnt_q > 3'd1);
	assign sts.more     = more_f;
	assign sts.any      = |dv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			dirty_q   <= '0;
			vptr_q    <= '0;
			nproc_q   <= 9'd1;
			nblk_q    <= 17'd65536;
			scan_q    <= '0;
			own_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_NUM_PROCESSES) nproc_q <= cfg_data[8:0];
				else nblk_q <= cfg_data;
			end
			if (own_start) own_cnt_q <= OWN_STEPS;
			else if (own_cnt_q != 3'd0) own_cnt_q <= own_cnt_q - 3'd1;
			if (cmd.load) scan_q <= '0;
			if (cmd.scan_next) scan_q <= dirty_i + IW'(1);
			if (cmd.exec) begin
				case (act_q)
					ACT_MARK: if (match_f) dirty_q[match_i] <= 1'b1;
					ACT_ALLOCATE: begin
						if (free_f) begin
							valid_q[free_i] <= 1'b1;
							dirty_q[free_i] <= 1'b0;
						end else begin
							vptr_q <= (vptr_q == IW'(ENTRIES-1)) ? '0 : vptr_q + IW'(1);
							if (!dirty_q[vptr_q] || old_rng)
								dirty_q[vptr_q] <= 1'b0;
						end
					end
					default: ;
				endcase
			end
			if (cmd.clear) begin
				valid_q <= '0;
				dirty_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action;
			blk_q <= BLOCK_BITS'(block_num);
		end
		if (cmd.exec && act_q == ACT_ALLOCATE) begin
			if (free_f) tag_q[free_i] <= blk_q;
			else if (!dirty_q[vptr_q] || old_rng)
				tag_q[vptr_q] <= blk_q;
		end
		if (own_start) begin
			own_blk_q <= own_src;
			own_rem_q <= '0;
		end else if (own_cnt_q != 3'd0) begin
			own_blk_q <= {own_blk_q[11:0], 4'd0};
			own_rem_q <= own_rem_d;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec || cmd.scan || cmd.none) begin
			hit <= 1'b0; slot <= '0; wb_valid <= 1'b0; wb_block <= '0;
			wb_owner <= '0; status <= 1'b0; last <= cmd.last;
			if (cmd.scan) begin
				slot     <= 5'(dirty_i);
				wb_block <= 16'(scan_b);
				if (scan_rng) wb_valid <= 1'b1;
				else status <= 1'b1;
			end else if (cmd.exec) begin
				if (act_q == ACT_ALLOCATE) begin
					if (free_f) begin
						hit <= 1'b1; slot <= 5'(free_i);
					end else begin
						slot <= 5'(vptr_q);
						if (!dirty_q[vptr_q]) hit <= 1'b1;
						else begin
							wb_block <= 16'(old_b);
							if (old_rng) begin
								hit <= 1'b1; wb_valid <= 1'b1;
							end else status <= 1'b1;
						end
					end
				end else if (match_f) begin
					hit <= 1'b1; slot <= 5'(match_i);
				end
			end
		end else if (own_cnt_q == 3'd1) begin
			wb_owner <= own_rem_d[7:0];
		end
	end

endmodule

@@ rtl/core/block_cache_directory_round_robin.sv @@
// Lookup, allocate, mark dirty: captured in IDLE, run in EXEC, result shown
// from OUT; an allocate with a write-back first waits in OWN for the owner
// remainder. Flush: one result per dirty slot, SCAN then FOUT (OWN between
// for an in-range write-back); with nothing dirty, EXEC goes to FOUT.
// Reset clears valid/dirty bits, victim pointer and registers to defaults.
`include "block_cache_directory_round_robin_macros.svh"
module block_cache_directory_round_robin import bcd_pkg::*; #(
	parameter int ENTRIES    = 32,
	parameter int BLOCK_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [15:0] block_num,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hit,
	output logic [4:0]  slot,
	output logic        wb_valid,
	output logic [15:0] wb_block,
	output logic [7:0]  wb_owner,
	output logic        status,
	output logic        last,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [16:0] cfg_data
);

	bcd_cmd_t cmd;
	bcd_sts_t sts;

	bcd_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
	);

	bcd_datapath #(.ENTRIES(ENTRIES), .BLOCK_BITS(BLOCK_BITS)) u_dp (
		.clk, .arst_n, .action, .block_num, .cfg_we, .cfg_index, .cfg_data,
		.cmd, .sts, .hit, .slot, .wb_valid, .wb_block, .wb_owner, .status, .last
	);

	`BCD_ASSERT_IMPL(a_no_accept_busy, out_valid, in_stall)
	`BCD_ASSERT_IMPL(a_wb_excl, out_valid, !(wb_valid && status))
	`BCD_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(slot))

endmodule

@@ sim/block_cache_directory_round_robin_tb.sv @@
module block_cache_directory_round_robin_tb;
	import bcd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 32;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic        hit;
		logic [4:0]  slot;
		logic        wb_valid;
		logic [15:0] wb_block;
		logic [7:0]  wb_owner;
		logic        status;
		logic        last;
	} dir_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	action_t     action;
	logic [15:0] block_num;
	logic        out_valid;
	logic        out_stall;
	logic        hit;
	logic [4:0]  slot;
	logic        wb_valid;
	logic [15:0] wb_block;
	logic [7:0]  wb_owner;
	logic        status;
	logic        last;
	logic        cfg_we;
	logic        cfg_index;
	logic [16:0] cfg_data;

	// directory mirror
	logic [15:0] tag_mirror [SLOTS];
	bit          valid_mirror [SLOTS];
	bit          dirty_mirror [SLOTS];
	logic [4:0]  victim_ptr;
	logic [8:0]  owner_count;
	logic [16:0] block_limit;

	dir_result_t pending_results [$];
	int          mismatches;
	int          cycles;
	int          send_gap_pct;
	int          stall_pct;

	block_cache_directory_round_robin dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .block_num(block_num),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .slot(slot), .wb_valid(wb_valid), .wb_block(wb_block),
		.wb_owner(wb_owner), .status(status), .last(last),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	function automatic logic [7:0] owner_of(logic [15:0] blk);
		int n;
		n = owner_count;
		if (n == 0) n = 1;
		if (n > 256) n = 256;
		return 8'(blk % n);
	endfunction

	function automatic dir_result_t make_result(logic h, int s, logic wv, logic [15:0] wb,
			logic [7:0] own, logic st);
		dir_result_t r;
		r.hit = h;
		r.slot = 5'(s);
		r.wb_valid = wv;
		r.wb_block = wb;
		r.wb_owner = own;
		r.status = st;
		r.last = 1'b0;
		return r;
	endfunction

	// work out the results of one accepted request and update the mirror
	function automatic void predict_directory(action_t act, logic [15:0] blk);
		dir_result_t res [$];
		int i;
		int found;
		int v;
		logic [15:0] old;
		found = -1;
		case (act)
			ACT_LOOKUP, ACT_MARK: begin
				for (i = SLOTS - 1; i >= 0; i--)
					if (valid_mirror[i] && tag_mirror[i] == blk) found = i;
				if (found >= 0) begin
					if (act == ACT_MARK) dirty_mirror[found] = 1'b1;
					res.push_back(make_result(1'b1, found, 1'b0, 16'd0, 8'd0, 1'b0));
				end else begin
					res.push_back(make_result(1'b0, 0, 1'b0, 16'd0, 8'd0, 1'b0));
				end
			end
			ACT_ALLOCATE: begin
				for (i = SLOTS - 1; i >= 0; i--)
					if (!valid_mirror[i]) found = i;
				if (found >= 0) begin
					tag_mirror[found] = blk;
					valid_mirror[found] = 1'b1;
					dirty_mirror[found] = 1'b0;
					res.push_back(make_result(1'b1, found, 1'b0, 16'd0, 8'd0, 1'b0));
				end else begin
					v = victim_ptr;
					victim_ptr = victim_ptr + 5'd1;
					old = tag_mirror[v];
					if (!dirty_mirror[v]) begin
						tag_mirror[v] = blk;
						res.push_back(make_result(1'b1, v, 1'b0, 16'd0, 8'd0, 1'b0));
					end else if (17'(old) >= block_limit) begin
						// keep the victim as it is
						res.push_back(make_result(1'b0, v, 1'b0, old, 8'd0, 1'b1));
					end else begin
						tag_mirror[v] = blk;
						dirty_mirror[v] = 1'b0;
						res.push_back(make_result(1'b1, v, 1'b1, old, owner_of(old), 1'b0));
					end
				end
			end
			default: begin
				for (i = 0; i < SLOTS; i++) begin
					if (valid_mirror[i] && dirty_mirror[i]) begin
						if (17'(tag_mirror[i]) < block_limit)
							res.push_back(make_result(1'b0, i, 1'b1, tag_mirror[i],
								owner_of(tag_mirror[i]), 1'b0));
						else
							res.push_back(make_result(1'b0, i, 1'b0, tag_mirror[i],
								8'd0, 1'b1));
					end
					valid_mirror[i] = 1'b0;
					dirty_mirror[i] = 1'b0;
				end
				if (res.size() == 0)
					res.push_back(make_result(1'b0, 0, 1'b0, 16'd0, 8'd0, 1'b0));
			end
		endcase
		res[res.size() - 1].last = 1'b1;
		foreach (res[k]) pending_results.push_back(res[k]);
	endfunction

	always @(posedge clk) begin
		dir_result_t got;
		dir_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {hit, slot, wb_valid, wb_block, wb_owner, status, last};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: %p", got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	task automatic send_request(action_t act, logic [15:0] blk);
		if ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		block_num <= blk;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_directory(act, blk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		// a flush clears the directory in the same cycle that its final result is formed
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [16:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		if (idx == REG_NUM_PROCESSES) owner_count = value[8:0];
		else block_limit = value;
	endtask

	task automatic configure(logic [16:0] procs, logic [16:0] blocks);
		drain();
		write_reg(REG_NUM_PROCESSES, procs);
		write_reg(REG_NUM_BLOCKS, blocks);
		cfg_we <= 1'b0;
	endtask

	task automatic test_directed;
		send_gap_pct = 0;
		stall_pct = 0;
		configure(17'd3, 17'd100);
		send_request(ACT_FLUSH, 16'hFFFF);
		send_request(ACT_LOOKUP, 16'd5);
		send_request(ACT_MARK, 16'd5);
		send_request(ACT_ALLOCATE, 16'd5);
		send_request(ACT_ALLOCATE, 16'hFFFF);
		send_request(ACT_ALLOCATE, 16'd5);
		send_request(ACT_LOOKUP, 16'd5);
		send_request(ACT_LOOKUP, 16'hFFFF);
		send_request(ACT_MARK, 16'd5);
		send_request(ACT_MARK, 16'hFFFF);
		send_request(ACT_MARK, 16'd0);
		send_request(ACT_FLUSH, 16'd0);
		send_request(ACT_ALLOCATE, 16'd0);
		send_request(ACT_MARK, 16'd0);
		send_request(ACT_ALLOCATE, 16'd99);
		send_request(ACT_MARK, 16'd99);
		configure(17'd0, 17'd0);
		send_request(ACT_FLUSH, 16'h5A5A);
	endtask

	function automatic logic [15:0] pick_block;
		if ($urandom_range(0, 9) == 0) return 16'($urandom);
		return 16'($urandom_range(0, 47));
	endfunction

	task automatic test_random(int count, int phase);
		int r;
		case (phase % 4)
			0: begin send_gap_pct = 0;  stall_pct = 0;  end
			1: begin send_gap_pct = 56; stall_pct = 0;  end
			2: begin send_gap_pct = 0;  stall_pct = 56; end
			default: begin send_gap_pct = 22; stall_pct = 22; end
		endcase
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 40) send_request(ACT_ALLOCATE, pick_block());
			else if (r < 65) send_request(ACT_LOOKUP, pick_block());
			else if (r < 97) send_request(ACT_MARK, pick_block());
			else send_request(ACT_FLUSH, 16'($urandom));
		end
	endtask

	task automatic test_settings;
		configure(17'd1, 17'd65536);
		test_random(85, 0);
		configure(17'd256, 17'd40);
		test_random(85, 1);
		configure(17'd511, 17'd131071);
		test_random(85, 2);
		configure(17'd7, 17'd1);
		test_random(85, 3);
		configure(17'd200, 17'd30);
		test_random(85, 1);
		configure(17'd0, 17'd20000);
		test_random(85, 0);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_LOOKUP;
		block_num = 16'd0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_NUM_PROCESSES;
		cfg_data = 17'd0;
		mismatches = 0;
		cycles = 0;
		send_gap_pct = 0;
		stall_pct = 0;
		foreach (tag_mirror[i]) begin
			tag_mirror[i] = 16'd0;
			valid_mirror[i] = 1'b0;
			dirty_mirror[i] = 1'b0;
		end
		victim_ptr = 5'd0;
		owner_count = 9'd1;
		block_limit = 17'd65536;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_settings();
		drain();
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
